@@ rtl/nmea_td_pkg.sv @@
// ----------------------------------------------------------------------------
// nmea_td_pkg
// types, register indexes and digit helpers for the nmea time and date extractor
// ----------------------------------------------------------------------------
`default_nettype none

package nmea_td_pkg;

  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_HOUR_OFFSET      = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DATE_COMMA_INDEX = 1'd1;

  localparam logic [4:0] HOUR_OFFSET_RESET      = 5'b11011;
  localparam logic [4:0] DATE_COMMA_INDEX_RESET = 5'd9;

  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [2:0] FIELD_LEN = 3'd6;
  localparam logic [4:0] COMMA_MAX = 5'd31;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_sentence;
  } in_item_t;

  typedef struct packed {
    logic [24:0] date_value;
    logic [18:0] time_seconds;
    logic        date_found;
    logic        time_found;
  } out_item_t;

  typedef struct packed {
    logic [5:0][7:0] time_chars;
    logic [5:0][7:0] date_chars;
    logic            time_found;
    logic            date_found;
  } snap_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [6:0] digit_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [3:0] h;
    logic [3:0] l;
    logic [6:0] v;
    h = 4'(hi - CHAR_ZERO);
    l = 4'(lo - CHAR_ZERO);
    if (!is_digit(hi)) begin
      v = 7'd0;
    end else if (is_digit(lo)) begin
      v = 7'(h) * 7'd10 + 7'(l);
    end else begin
      v = 7'(h);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/nmea_td_capture.sv @@
// ----------------------------------------------------------------------------
// nmea_td_capture
// counts commas, captures the time and date characters, hands a snapshot per sentence
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_td_capture (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  byte_valid,
  output logic                       byte_ready,
  input  wire nmea_td_pkg::in_item_t byte_item,
  input  wire logic [4:0]            date_comma_index,
  output logic                       snap_valid,
  input  wire logic                  snap_ready,
  output nmea_td_pkg::snap_t         snap
);

  logic [4:0]      comma_count;
  logic [2:0]      time_char_count;
  logic [2:0]      date_char_count;
  logic [5:0][7:0] time_chars;
  logic [5:0][7:0] date_chars;

  logic [4:0]      comma_count_next;
  logic [2:0]      time_char_count_next;
  logic [2:0]      date_char_count_next;
  logic [5:0][7:0] time_chars_next;
  logic [5:0][7:0] date_chars_next;
  logic            time_cap;
  logic            date_cap;
  logic            accept;

  assign byte_ready = !snap_valid || snap_ready;
  assign accept     = byte_valid && byte_ready;

  always_comb begin
    time_cap = (comma_count != 5'd0) && (time_char_count < nmea_td_pkg::FIELD_LEN);
    date_cap = (comma_count >= date_comma_index) &&
               (date_char_count < nmea_td_pkg::FIELD_LEN);
    time_chars_next = time_chars;
    date_chars_next = date_chars;
    for (int i = 0; i < 6; i++) begin
      if (time_cap && time_char_count == 3'(i)) begin
        time_chars_next[i] = byte_item.byte_value;
      end
      if (date_cap && date_char_count == 3'(i)) begin
        date_chars_next[i] = byte_item.byte_value;
      end
    end
    time_char_count_next = time_cap ? time_char_count + 3'd1 : time_char_count;
    date_char_count_next = date_cap ? date_char_count + 3'd1 : date_char_count;
    if (byte_item.byte_value == nmea_td_pkg::CHAR_COMMA &&
        comma_count < nmea_td_pkg::COMMA_MAX) begin
      comma_count_next = comma_count + 5'd1;
    end else begin
      comma_count_next = comma_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comma_count     <= '0;
      time_char_count <= '0;
      date_char_count <= '0;
      snap_valid      <= 1'b0;
    end else begin
      if (accept && byte_item.end_of_sentence) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
      if (accept) begin
        if (byte_item.end_of_sentence) begin
          comma_count     <= '0;
          time_char_count <= '0;
          date_char_count <= '0;
        end else begin
          comma_count     <= comma_count_next;
          time_char_count <= time_char_count_next;
          date_char_count <= date_char_count_next;
        end
      end
    end
  end

  // payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      time_chars <= time_chars_next;
      date_chars <= date_chars_next;
      if (byte_item.end_of_sentence) begin
        snap.time_chars <= time_chars_next;
        snap.date_chars <= date_chars_next;
        snap.time_found <= (time_char_count_next == nmea_td_pkg::FIELD_LEN);
        snap.date_found <= (date_char_count_next == nmea_td_pkg::FIELD_LEN);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/nmea_td_convert.sv @@
// ----------------------------------------------------------------------------
// nmea_td_convert
// turns a captured sentence into date and seconds, holds the result register
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_td_convert (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               snap_valid,
  output logic                    snap_ready,
  input  wire nmea_td_pkg::snap_t snap,
  input  wire logic [4:0]         hour_offset,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output nmea_td_pkg::out_item_t  result_item
);

  logic [6:0]  dd, mo, yy, hp, mi, ss;
  logic [8:0]  hh;
  logic [8:0]  hh_adj;
  logic [24:0] date_calc;
  logic [18:0] time_calc;
  nmea_td_pkg::out_item_t result_next;

  assign snap_ready = !result_valid || result_ready;

  always_comb begin
    dd = nmea_td_pkg::digit_pair(snap.date_chars[0], snap.date_chars[1]);
    mo = nmea_td_pkg::digit_pair(snap.date_chars[2], snap.date_chars[3]);
    yy = nmea_td_pkg::digit_pair(snap.date_chars[4], snap.date_chars[5]);
    hp = nmea_td_pkg::digit_pair(snap.time_chars[0], snap.time_chars[1]);
    mi = nmea_td_pkg::digit_pair(snap.time_chars[2], snap.time_chars[3]);
    ss = nmea_td_pkg::digit_pair(snap.time_chars[4], snap.time_chars[5]);

    date_calc = 25'(yy) * 25'd10000 + 25'd20000000 + 25'(mo) * 25'd100 + 25'(dd);

    // signed hour sum, one wrap when negative
    hh     = {2'b00, hp} + {{4{hour_offset[4]}}, hour_offset};
    hh_adj = hh[8] ? hh + 9'd24 : hh;
    time_calc = 19'(hh_adj[6:0]) * 19'd3600 + 19'(mi) * 19'd60 + 19'(ss);

    result_next.date_found   = snap.date_found;
    result_next.time_found   = snap.time_found;
    result_next.date_value   = snap.date_found ? date_calc : 25'd0;
    result_next.time_seconds = snap.time_found ? time_calc : 19'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (snap_ready) begin
      result_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      result_item <= result_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/nmea_time_date_extractor.sv @@
// ----------------------------------------------------------------------------
// nmea_time_date_extractor
// takes a sentence byte by byte, gives one time and date item per sentence
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// byte      in         byte_valid / byte_ready    byte_item (in_item_t)
// result    out        result_valid / result_ready result_item (out_item_t)
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one byte item per cycle while byte_ready is high; after its last byte a result
// passes the snapshot register, then the result register
// rst clears counters, valids and loads hour_offset -5, date_comma_index 9
// byte_ready drops only while a finished sentence waits in both registers
// cfg_ready is always high
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_time_date_extractor (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 byte_valid,
  output logic                                      byte_ready,
  input  wire nmea_td_pkg::in_item_t                byte_item,
  output logic                                      result_valid,
  input  wire logic                                 result_ready,
  output nmea_td_pkg::out_item_t                    result_item,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [nmea_td_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [4:0]                           cfg_data
);

  logic [4:0]         hour_offset;
  logic [4:0]         date_comma_index;
  logic               snap_valid;
  logic               snap_ready;
  nmea_td_pkg::snap_t snap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_offset      <= nmea_td_pkg::HOUR_OFFSET_RESET;
      date_comma_index <= nmea_td_pkg::DATE_COMMA_INDEX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nmea_td_pkg::CFG_HOUR_OFFSET:      hour_offset      <= cfg_data;
        nmea_td_pkg::CFG_DATE_COMMA_INDEX: date_comma_index <= cfg_data;
        default: ;
      endcase
    end
  end

  nmea_td_capture u_capture (
    .clk              (clk),
    .rst              (rst),
    .byte_valid       (byte_valid),
    .byte_ready       (byte_ready),
    .byte_item        (byte_item),
    .date_comma_index (date_comma_index),
    .snap_valid       (snap_valid),
    .snap_ready       (snap_ready),
    .snap             (snap)
  );

  nmea_td_convert u_convert (
    .clk          (clk),
    .rst          (rst),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap         (snap),
    .hour_offset  (hour_offset),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

`default_nettype wire

@@ bench/nmea_time_date_extractor_tb.sv @@
// ----------------------------------------------------------------------------
// nmea_time_date_extractor_tb
// self-checking bench for the nmea time and date extractor
//
// feeds sentences byte by byte (rmc-like sentences with random content,
// truncated ones and raw noise) over several hour offset and date comma
// settings. a scoreboard class tracks commas and captured characters,
// predicts the time and date item for every end of sentence, and checks
// each result item against it in order. the byte sender idles in random
// bursts and the result side stalls on its own changing pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_time_date_extractor_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 210;
  localparam int N_PHASES    = 8;

  class time_date_scoreboard;
    logic [4:0]             hour_off;
    logic [4:0]             date_idx;
    logic [4:0]             commas;
    logic [2:0]             time_len;
    logic [2:0]             date_len;
    logic [5:0][7:0]        time_buf;
    logic [5:0][7:0]        date_buf;
    nmea_td_pkg::out_item_t expected_fixes[$];
    int                     errors;

    function new();
      hour_off = nmea_td_pkg::HOUR_OFFSET_RESET;
      date_idx = nmea_td_pkg::DATE_COMMA_INDEX_RESET;
      commas   = '0;
      time_len = '0;
      date_len = '0;
      time_buf = '0;
      date_buf = '0;
      errors   = 0;
    endfunction

    function void set_reg(logic [nmea_td_pkg::CFG_INDEX_W-1:0] idx, logic [4:0] data);
      case (idx)
        nmea_td_pkg::CFG_HOUR_OFFSET: hour_off = data;
        nmea_td_pkg::CFG_DATE_COMMA_INDEX: date_idx = data;
        default: ;
      endcase
    endfunction

    // atol-like read of two characters
    function int pair_value(logic [7:0] hi, logic [7:0] lo);
      int h;
      int l;
      h = int'(hi) - int'(nmea_td_pkg::CHAR_ZERO);
      l = int'(lo) - int'(nmea_td_pkg::CHAR_ZERO);
      if (h < 0 || h > 9) return 0;
      if (l < 0 || l > 9) return h;
      return h * 10 + l;
    endfunction

    function void note_byte(nmea_td_pkg::in_item_t it);
      nmea_td_pkg::out_item_t fix;
      int                     hh;
      int                     offs;
      if (commas >= 5'd1 && time_len < nmea_td_pkg::FIELD_LEN) begin
        time_buf[time_len] = it.byte_value;
        time_len++;
      end
      if (commas >= date_idx && date_len < nmea_td_pkg::FIELD_LEN) begin
        date_buf[date_len] = it.byte_value;
        date_len++;
      end
      if (it.byte_value == nmea_td_pkg::CHAR_COMMA && commas < nmea_td_pkg::COMMA_MAX)
        commas++;
      if (!it.end_of_sentence) return;

      fix = '0;
      fix.date_found = (date_len == nmea_td_pkg::FIELD_LEN);
      fix.time_found = (time_len == nmea_td_pkg::FIELD_LEN);
      if (fix.date_found) begin
        fix.date_value = 25'((2000 + pair_value(date_buf[4], date_buf[5])) * 10000
                             + pair_value(date_buf[2], date_buf[3]) * 100
                             + pair_value(date_buf[0], date_buf[1]));
      end
      if (fix.time_found) begin
        offs = hour_off[4] ? int'(hour_off) - 32 : int'(hour_off);
        hh = pair_value(time_buf[0], time_buf[1]) + offs;
        if (hh < 0) hh += 24;
        fix.time_seconds = 19'(hh * 3600 + pair_value(time_buf[2], time_buf[3]) * 60
                               + pair_value(time_buf[4], time_buf[5]));
      end
      expected_fixes.push_back(fix);
      commas   = '0;
      time_len = '0;
      date_len = '0;
      time_buf = '0;
      date_buf = '0;
    endfunction

    function void check_result(nmea_td_pkg::out_item_t got);
      nmea_td_pkg::out_item_t exp_fix;
      if (expected_fixes.size() == 0) begin
        $error("result item with none expected: %h", got);
        errors++;
        return;
      end
      exp_fix = expected_fixes.pop_front();
      if (got.date_value !== exp_fix.date_value) begin
        $error("date_value: expected %0d, got %0d", exp_fix.date_value, got.date_value);
        errors++;
      end
      if (got.time_seconds !== exp_fix.time_seconds) begin
        $error("time_seconds: expected %0d, got %0d", exp_fix.time_seconds,
               got.time_seconds);
        errors++;
      end
      if (got.date_found !== exp_fix.date_found) begin
        $error("date_found: expected %0d, got %0d", exp_fix.date_found, got.date_found);
        errors++;
      end
      if (got.time_found !== exp_fix.time_found) begin
        $error("time_found: expected %0d, got %0d", exp_fix.time_found, got.time_found);
        errors++;
      end
    endfunction

    function int pending();
      return expected_fixes.size();
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                byte_valid = 1'b0;
  logic                                byte_ready;
  nmea_td_pkg::in_item_t               byte_item = '0;
  logic                                result_valid;
  logic                                result_ready = 1'b0;
  nmea_td_pkg::out_item_t              result_item;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [nmea_td_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [4:0]                          cfg_data = '0;

  time_date_scoreboard sb = new();

  logic [7:0] sentence_q[$];
  int         burst_left = 0;
  int         phase_sent;
  int         cycles = 0;
  logic [1:0] stall_mode = 2'd0;

  nmea_time_date_extractor u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: stall pattern is drawn anew whenever the low byte of the cycle counter is zero
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) sb.check_result(result_item);
      if (cycles[7:0] == 8'd0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0: result_ready <= 1'b1;
        2'd1: result_ready <= ($urandom_range(0, 3) != 0);
        2'd2: result_ready <= (cycles[2:0] < 3'd3);
        default: result_ready <= (cycles[4:0] == 5'd0);
      endcase
    end
  end

  task automatic send_byte(input nmea_td_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_item  <= it;
    do @(posedge clk); while (!byte_ready);
    sb.note_byte(it);
    phase_sent++;
  endtask

  task automatic send_sentence();
    nmea_td_pkg::in_item_t it;
    for (int k = 0; k < sentence_q.size(); k++) begin
      it.byte_value      = sentence_q[k];
      it.end_of_sentence = (k == sentence_q.size() - 1);
      send_byte(it);
    end
  endtask

  task automatic load_text(input string s);
    sentence_q.delete();
    for (int k = 0; k < s.len(); k++) sentence_q.push_back(s[k]);
  endtask

  function automatic logic [7:0] digit_char();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return nmea_td_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    return (c == nmea_td_pkg::CHAR_COMMA) ? 8'h2e : c;
  endfunction

  // well-formed, truncated or noise sentence for the given date comma index
  task automatic build_sentence(input logic [4:0] didx);
    string hdr;
    int    kind;
    int    n;
    int    ncommas;
    hdr = "$GPRMC";
    kind = $urandom_range(0, 9);
    sentence_q.delete();
    if (kind < 2) begin
      n = $urandom_range(1, 24);
      for (int k = 0; k < n; k++)
        sentence_q.push_back(($urandom_range(0, 5) == 0) ? nmea_td_pkg::CHAR_COMMA
                                                         : 8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 6);
      for (int k = 0; k < n; k++) sentence_q.push_back(hdr[k]);
      sentence_q.push_back(nmea_td_pkg::CHAR_COMMA);
      ncommas = 1;
      for (int k = 0; k < 6; k++) sentence_q.push_back(digit_char());
      while (ncommas < int'(didx)) begin
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) sentence_q.push_back(filler_char());
        sentence_q.push_back(nmea_td_pkg::CHAR_COMMA);
        ncommas++;
      end
      for (int k = 0; k < 6; k++) sentence_q.push_back(digit_char());
      n = $urandom_range(0, 6);
      for (int k = 0; k < n; k++)
        sentence_q.push_back(($urandom_range(0, 2) == 0) ? nmea_td_pkg::CHAR_COMMA
                                                         : filler_char());
      if (kind == 2) begin
        n = $urandom_range(1, sentence_q.size());
        while (sentence_q.size() > n) void'(sentence_q.pop_back());
      end
    end
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input int offs, input logic [4:0] didx);
    cfg_valid <= 1'b1;
    cfg_index <= nmea_td_pkg::CFG_HOUR_OFFSET;
    cfg_data  <= 5'(offs);
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(nmea_td_pkg::CFG_HOUR_OFFSET, 5'(offs));
    cfg_index <= nmea_td_pkg::CFG_DATE_COMMA_INDEX;
    cfg_data  <= didx;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(nmea_td_pkg::CFG_DATE_COMMA_INDEX, didx);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int         offs_list[N_PHASES];
    logic [4:0] idx_list[N_PHASES];
    offs_list = '{-16, 15, -12, 12, 0, -1, 0, 0};
    idx_list  = '{5'd31, 5'd1, 5'd9, 5'd2, 5'd9, 5'd5, 5'd0, 5'd0};
    offs_list[6] = $urandom_range(0, 31) - 16;
    offs_list[7] = $urandom_range(0, 31) - 16;
    idx_list[6]  = 5'($urandom_range(0, 31));
    idx_list[7]  = 5'($urandom_range(3, 12));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: no comma, byte extremes, negative hour wrap, non-digits
    sentence_q.delete();
    sentence_q.push_back(8'hff);
    send_sentence();
    load_text(",013/05,,,,,,,,3112:9");
    send_sentence();
    byte_valid <= 1'b0;
    drain();

    // date from the first byte, largest hour plus offset
    write_config(15, 5'd0);
    load_text(",99,999");
    send_sentence();
    byte_valid <= 1'b0;
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_config(offs_list[p], idx_list[p]);
      phase_sent = 0;
      while (phase_sent < PHASE_BYTES) begin
        build_sentence(idx_list[p]);
        send_sentence();
      end
      byte_valid <= 1'b0;
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/nmea_td_pkg.sv
rtl/nmea_td_capture.sv
rtl/nmea_td_convert.sv
rtl/nmea_time_date_extractor.sv
bench/nmea_time_date_extractor_tb.sv
